[rtl/core/prrs_pkg.sv]
// Package for the priority round-robin scheduler.
// Task record, controller state and command/status types. No dependencies.
`timescale 1ns / 1ps
package prrs_pkg;

   localparam logic OP_ARRIVE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef struct packed {
      logic [7:0]  id;
      logic [7:0]  prio;
      logic [15:0] rem;
   } task_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ARRIVE,
      ST_DECIDE,
      ST_RUN,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request fields
      logic scan_clr;  // start priority-store scan
      logic scan_step; // compare one slot
      logic arrive;    // store arriving task
      logic decide;    // dispatch / preempt
      logic run;       // run one unit, write result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic opcode;
      logic scan_last;
   } status_type;

endpackage

[rtl/core/prrs_datapath.sv]
// Datapath of the priority round-robin scheduler: priority store, FIFO memory,
// current task, serial best-slot search and result registers. Uses prrs_pkg.
`timescale 1ns / 1ps
module prrs_datapath
   import prrs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        req_opcode,
   input  logic [7:0]  req_task_id,
   input  logic [7:0]  req_task_priority,
   input  logic [15:0] req_task_burst,
   input  logic [15:0] quantum_length,
   output logic        rsp_arrival_accepted,
   output logic        rsp_ran_task,
   output logic [7:0]  rsp_running_id,
   output logic        rsp_task_finished,
   output logic        rsp_quantum_expired,
   output logic        rsp_preempted
);
   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IW-1:0] LAST = IW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

   task_type                  store_ff [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]    valid_ff;
   task_type                  fifo_mem [QUEUE_DEPTH];
   logic [IW-1:0]             head_ff, tail_ff;
   logic [CW-1:0]             count_ff;
   task_type                  cur_ff;
   logic                      busy_ff, from_rr_ff;
   logic [15:0]               qleft_ff;

   logic                      op_ff;
   task_type                  new_ff;
   logic [IW-1:0]             idx_ff;
   logic                      found_ff;
   logic [IW-1:0]             best_ff;
   task_type                  best_task_ff;
   task_type                  fifo_rd_ff;

   logic [15:0] reload;
   assign reload = (quantum_length == 16'd0) ? 16'd1 : quantum_length;
   assign status.opcode    = op_ff;
   assign status.scan_last = (idx_ff == LAST);

   // lowest free slot
   logic          free_any;
   logic [IW-1:0] free_idx;
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   // one slot of the search
   task_type cand;
   logic     better;
   assign cand = store_ff[idx_ff];
   assign better = valid_ff[idx_ff] && (!found_ff || cand.prio < best_task_ff.prio ||
                   (cand.prio == best_task_ff.prio && cand.id < best_task_ff.id));

   logic [IW-1:0] head_nx, tail_nx;
   assign head_nx = (head_ff == LAST) ? '0 : head_ff + 1'b1;
   assign tail_nx = (tail_ff == LAST) ? '0 : tail_ff + 1'b1;

   // FIFO memory: registered read of head
   logic     push_en;
   task_type push_data;
   always_ff @(posedge clock) begin
      if (push_en) fifo_mem[tail_ff] <= push_data;
      fifo_rd_ff <= fifo_mem[head_ff];
   end

   // tick work, computed from state registered after decide
   task_type cur_run;
   logic [15:0] q_run;
   logic fin, exp_try, push_ok;
   always_comb begin
      cur_run = cur_ff;
      if (cur_run.rem != 16'd0) cur_run.rem = cur_run.rem - 16'd1;
      q_run = (qleft_ff != 16'd0) ? qleft_ff - 16'd1 : 16'd0;
      fin = busy_ff && (cur_run.rem == 16'd0);
      exp_try = busy_ff && !fin && (q_run == 16'd0);
      push_ok = count_ff != FULL;
   end

   // decide step
   logic want, do_pre;
   assign want = from_rr_ff || (best_task_ff.prio < cur_ff.prio);
   assign do_pre = cmd.decide && busy_ff && found_ff && want && push_ok;

   always_comb begin
      push_en = 1'b0;
      push_data = cur_ff;
      if (do_pre) push_en = 1'b1;
      if (cmd.run && exp_try && push_ok) begin
         push_en = 1'b1;
         push_data = cur_run;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_opcode;
         new_ff.id <= req_task_id;
         new_ff.prio <= req_task_priority;
         new_ff.rem <= (req_task_burst == 16'd0) ? 16'd1 : req_task_burst;
      end
      if (cmd.scan_clr) begin
         idx_ff <= '0;
      end else if (cmd.scan_step) begin
         if (better) begin
            best_ff <= idx_ff;
            best_task_ff <= cand;
         end
         if (idx_ff != LAST) idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.arrive && free_any) store_ff[free_idx] <= new_ff;
      if (cmd.arrive) begin
         rsp_arrival_accepted <= free_any;
         rsp_ran_task <= 1'b0;
         rsp_running_id <= 8'd0;
         rsp_task_finished <= 1'b0;
         rsp_quantum_expired <= 1'b0;
         rsp_preempted <= 1'b0;
      end
      if (cmd.decide) begin
         rsp_preempted <= do_pre;
         if (!busy_ff && found_ff) begin
            cur_ff <= best_task_ff;
            qleft_ff <= reload;
         end else if (!busy_ff && count_ff != '0) begin
            cur_ff <= fifo_rd_ff;
            qleft_ff <= reload;
         end else if (do_pre) begin
            cur_ff <= best_task_ff;
            qleft_ff <= reload;
         end
      end
      if (cmd.run) begin
         rsp_arrival_accepted <= 1'b0;
         rsp_ran_task <= busy_ff;
         rsp_running_id <= busy_ff ? cur_ff.id : 8'd0;
         rsp_task_finished <= fin;
         rsp_quantum_expired <= exp_try && push_ok;
         if (busy_ff) begin
            cur_ff.rem <= cur_run.rem;
            qleft_ff <= (exp_try && !push_ok) ? reload : q_run;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         busy_ff <= 1'b0;
         from_rr_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         if (cmd.scan_clr) found_ff <= 1'b0;
         else if (cmd.scan_step && better) found_ff <= 1'b1;
         if (cmd.arrive && free_any) valid_ff[free_idx] <= 1'b1;
         if (cmd.decide) begin
            if (!busy_ff && found_ff) begin
               valid_ff[best_ff] <= 1'b0;
               busy_ff <= 1'b1;
               from_rr_ff <= 1'b0;
            end else if (!busy_ff && count_ff != '0) begin
               head_ff <= head_nx;
               count_ff <= count_ff - 1'b1;
               busy_ff <= 1'b1;
               from_rr_ff <= 1'b1;
            end else if (do_pre) begin
               valid_ff[best_ff] <= 1'b0;
               tail_ff <= tail_nx;
               count_ff <= count_ff + 1'b1;
               from_rr_ff <= 1'b0;
            end
         end
         if (cmd.run) begin
            if (fin) begin
               busy_ff <= 1'b0;
               from_rr_ff <= 1'b0;
            end else if (exp_try && push_ok) begin
               busy_ff <= 1'b0;
               from_rr_ff <= 1'b0;
               tail_ff <= tail_nx;
               count_ff <= count_ff + 1'b1;
            end
         end
      end
   end
endmodule

[rtl/core/prrs_ctrl.sv]
// Controller of the priority round-robin scheduler: sequences load and store
// steps for arrivals, and load, search, dispatch and run steps for ticks. Uses prrs_pkg.
`timescale 1ns / 1ps
module prrs_ctrl
   import prrs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   output logic       rsp_valid,
   output cmd_type    cmd,
   input  status_type status
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               cmd.scan_clr = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.opcode == OP_ARRIVE) begin
               state_in = ST_ARRIVE;
            end else begin
               cmd.scan_step = 1'b1;
               if (status.scan_last) state_in = ST_DECIDE;
            end
         end
         ST_ARRIVE: begin
            cmd.arrive = 1'b1;
            state_in = ST_DONE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            cmd.run = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

[rtl/core/priority_round_robin_scheduler.sv]
// Top level of the priority round-robin scheduler.
// Holds the quantum register and joins prrs_ctrl and prrs_datapath; uses prrs_pkg.
`timescale 1ns / 1ps
// Usage:
//   Request channel: drive req_* and raise start while busy is low; the request
//   is taken at that edge. opcode 0 stores an arriving task, opcode 1 is a tick.
//   Result channel: rsp_valid is high for one cycle with the rsp_* fields; the
//   receiver cannot stall and must take it then.
//   CSR channel: csr_valid/csr_ready write quantum_length (always ready); write
//   only while the block is idle.
// Sequence: an arrival passes the scan, arrive and done states to its result; a
//   tick runs the serial search over the priority store, one slot per cycle,
//   then the decide, run and done states. busy is low again in the cycle after
//   rsp_valid, so the next request can be taken then; no new request is taken
//   while one is still in progress.
// Reset: synchronous, clears the store valid bits, FIFO pointers, running task
//   state and sets quantum_length to 4. No clearing pass is needed.
module priority_round_robin_scheduler
   import prrs_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [7:0]  req_task_id,
   input  logic [7:0]  req_task_priority,
   input  logic [15:0] req_task_burst,
   output logic        rsp_valid,
   output logic        rsp_arrival_accepted,
   output logic        rsp_ran_task,
   output logic [7:0]  rsp_running_id,
   output logic        rsp_task_finished,
   output logic        rsp_quantum_expired,
   output logic        rsp_preempted,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   cmd_type     cmd;
   status_type  status;
   logic [15:0] quantum_ff;

   // quantum register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) quantum_ff <= 16'd4;
      else if (csr_valid && csr_ready) quantum_ff <= csr_data;
   end

   prrs_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .rsp_valid(rsp_valid), .cmd(cmd), .status(status)
   );

   prrs_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_opcode(req_opcode), .req_task_id(req_task_id),
      .req_task_priority(req_task_priority), .req_task_burst(req_task_burst),
      .quantum_length(quantum_ff),
      .rsp_arrival_accepted(rsp_arrival_accepted), .rsp_ran_task(rsp_ran_task),
      .rsp_running_id(rsp_running_id), .rsp_task_finished(rsp_task_finished),
      .rsp_quantum_expired(rsp_quantum_expired), .rsp_preempted(rsp_preempted)
   );
endmodule
